[rtl/fltw_pkg.sv]
// ----------------------------------------------------------------------------
// fltw_pkg
// Shared types and constants of the four-level page-table walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fltw_pkg;

    localparam int TABLE_PAGES       = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int STORE_DEPTH       = TABLE_PAGES * ENTRIES_PER_TABLE;
    localparam int PAGE_W            = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int ADDR_W            = PAGE_W + IDX_W;

    localparam int ROOT_W   = 4;
    localparam int VA_W     = 48;
    localparam int SLOT_W   = 13;
    localparam int ENTRY_W  = 64;
    localparam int FRAME_W  = 40;
    localparam int PA_W     = 52;
    localparam int STATUS_W = 3;
    localparam int LEVEL_W  = 2;
    localparam int OFFS_W   = 12;

    // apb register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_ROOT_TABLE_PAGE = 1'b0;

    // entry layout
    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;
    localparam int FRAME_LSB   = 12;

    // walk levels, counted down from the top-level table
    localparam logic [LEVEL_W-1:0] LVL_4 = 2'd3;
    localparam logic [LEVEL_W-1:0] LVL_3 = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_2 = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_1 = 2'd0;

    localparam logic ACT_WRITE     = 1'b0;
    localparam logic ACT_TRANSLATE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STS_WRITE_DONE = 3'd0,
        STS_NOT_MAPPED = 3'd1,
        STS_PAGE_4K    = 3'd2,
        STS_PAGE_2M    = 3'd3,
        STS_PAGE_1G    = 3'd4,
        STS_BAD_TABLE  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic walk_step;
        logic load_walk;
        logic load_resp;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic item_write;
        logic root_oob;
        logic walk_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

[rtl/four_level_page_table_walker.sv]
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level x86-64 style page-table walker over a local entry store.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (i_valid / o_stall) carries one request: a write of one
//   64-bit entry into slot i_entry_slot, or a translate of a 48-bit virtual
//   address. every request gives exactly one result on the output channel
//   (o_valid / i_stall) with status, frame number, physical address and the
//   last-level table page for 4 KiB leaves.
//   root_table_page is set over the apb port at byte address 0.
//   a write, or a translate with a root page outside the store, loads its
//   result into the output register from the response state once that is
//   free; other translates read one level at a time from the synchronous
//   entry store and load the result when the walk ends and the output
//   register is free. no new request is taken before the result is loaded.
//   o_valid rises right at the load edge. after reset the store is swept
//   to zero, one entry a cycle; o_stall stays high until the sweep is done.
//   a new request is taken while the previous result waits in the output
//   register; if the receiver stalls, a finished walk holds until the
//   output register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_table_walker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fltw_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [fltw_pkg::PDATA_W-1:0]    pwdata,
    output logic [fltw_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_action,
    input  wire logic [fltw_pkg::VA_W-1:0]       i_virtual_address,
    input  wire logic [fltw_pkg::SLOT_W-1:0]     i_entry_slot,
    input  wire logic [fltw_pkg::ENTRY_W-1:0]    i_entry_value,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [fltw_pkg::STATUS_W-1:0]        o_status,
    output logic [fltw_pkg::FRAME_W-1:0]         o_frame_number,
    output logic [fltw_pkg::PA_W-1:0]            o_physical_address,
    output logic [fltw_pkg::FRAME_W-1:0]         o_leaf_table_page
);
    import fltw_pkg::*;

    logic [ROOT_W-1:0] r_root_page;
    logic              root_sel;
    t_cmd              cmd;
    t_stat             stat;

    assign root_sel = (paddr[PADDR_W-1:2] == REG_ROOT_TABLE_PAGE);
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_page <= '0;
        end else if (psel && penable && pwrite && pready && root_sel) begin
            r_root_page <= pwdata[ROOT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (root_sel) prdata = PDATA_W'(r_root_page);
    end

    fltw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    fltw_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_root_page        (r_root_page),
        .i_action           (i_action),
        .i_virtual_address  (i_virtual_address),
        .i_entry_slot       (i_entry_slot),
        .i_entry_value      (i_entry_value),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_frame_number     (o_frame_number),
        .o_physical_address (o_physical_address),
        .o_leaf_table_page  (o_leaf_table_page)
    );

endmodule

`default_nettype wire

[rtl/fltw_ctrl.sv]
// ----------------------------------------------------------------------------
// fltw_ctrl
// Sequencer of the walker: store clear after reset, request intake, walk
// levels and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fltw_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire fltw_pkg::t_stat i_stat,
    output fltw_pkg::t_cmd     o_cmd
);
    import fltw_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_stat.item_write || i_stat.root_oob) n_state = ST_RESP;
                    else n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_stat.walk_done && i_stat.out_free) n_state = ST_IDLE;
            end
            ST_RESP: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_stall          = (r_state != ST_IDLE);
        o_cmd.clear_step = (r_state == ST_CLEAR);
        o_cmd.accept     = accept;
        o_cmd.walk_step  = (r_state == ST_WALK) && !i_stat.walk_done;
        // a finished walk waits here while the output register is still full
        o_cmd.load_walk  = (r_state == ST_WALK) && i_stat.walk_done && i_stat.out_free;
        o_cmd.load_resp  = (r_state == ST_RESP) && i_stat.out_free;
    end

endmodule

`default_nettype wire

[rtl/fltw_datapath.sv]
// ----------------------------------------------------------------------------
// fltw_datapath
// Entry store, walk registers, entry decode and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fltw_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [fltw_pkg::ROOT_W-1:0]     i_root_page,
    input  wire logic                            i_action,
    input  wire logic [fltw_pkg::VA_W-1:0]       i_virtual_address,
    input  wire logic [fltw_pkg::SLOT_W-1:0]     i_entry_slot,
    input  wire logic [fltw_pkg::ENTRY_W-1:0]    i_entry_value,
    input  wire fltw_pkg::t_cmd                  i_cmd,
    output fltw_pkg::t_stat                      o_stat,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [fltw_pkg::STATUS_W-1:0]        o_status,
    output logic [fltw_pkg::FRAME_W-1:0]         o_frame_number,
    output logic [fltw_pkg::PA_W-1:0]            o_physical_address,
    output logic [fltw_pkg::FRAME_W-1:0]         o_leaf_table_page
);
    import fltw_pkg::*;

    logic [ENTRY_W-1:0] r_store [STORE_DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    logic [ADDR_W-1:0]  r_clr_addr;
    logic [VA_W-1:0]    r_va;
    logic [LEVEL_W-1:0] r_level;
    logic [PAGE_W-1:0]  r_table;
    t_status            r_pend_status;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [FRAME_W-1:0]  r_out_frame;
    logic [PA_W-1:0]     r_out_pa;
    logic [FRAME_W-1:0]  r_out_leaf;

    logic               item_write;
    logic               root_oob;
    logic               slot_ok;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    logic               ent_present;
    logic               ent_large;
    logic [FRAME_W-1:0] ent_frame;
    logic [PA_W-1:0]    frame_base;
    logic               frame_oob;
    logic [IDX_W-1:0]   next_idx;

    logic               walk_done;
    t_status            walk_status;
    logic [FRAME_W-1:0] walk_frame;
    logic [PA_W-1:0]    walk_pa;
    logic [FRAME_W-1:0] walk_leaf;

    assign item_write = (i_action == ACT_WRITE);
    assign root_oob   = 32'(i_root_page) >= TABLE_PAGES;
    assign slot_ok    = 32'(i_entry_slot) < STORE_DEPTH;

    // store port selection: clear sweep, write request, walk reads
    always_comb begin
        mem_we    = i_cmd.clear_step || (i_cmd.accept && item_write && slot_ok);
        mem_waddr = i_cmd.clear_step ? r_clr_addr : ADDR_W'(i_entry_slot);
        mem_wdata = i_cmd.clear_step ? '0 : i_entry_value;
        mem_re    = (i_cmd.accept && !item_write && !root_oob) || i_cmd.walk_step;
        if (i_cmd.accept) begin
            mem_raddr = {PAGE_W'(i_root_page), i_virtual_address[47:39]};
        end else begin
            mem_raddr = {PAGE_W'(ent_frame), next_idx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_store[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_store[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_comb begin
        case (r_level)
            LVL_4:   next_idx = r_va[38:30];
            LVL_3:   next_idx = r_va[29:21];
            default: next_idx = r_va[20:12];
        endcase
    end

    // decode of the entry read for the current level
    always_comb begin
        ent_present = r_rdata[PRESENT_BIT];
        ent_large   = r_rdata[LARGE_BIT];
        ent_frame   = r_rdata[FRAME_LSB +: FRAME_W];
        frame_base  = {ent_frame, {OFFS_W{1'b0}}};
        frame_oob   = ent_frame >= FRAME_W'(TABLE_PAGES);

        walk_done   = 1'b1;
        walk_status = STS_NOT_MAPPED;
        walk_frame  = '0;
        walk_pa     = '0;
        walk_leaf   = '0;
        if (!ent_present) begin
            walk_status = STS_NOT_MAPPED;
        end else if (r_level == LVL_1) begin
            walk_status = STS_PAGE_4K;
            walk_frame  = ent_frame;
            walk_pa     = frame_base | PA_W'(r_va[11:0]);
            walk_leaf   = FRAME_W'(r_table);
        end else if (r_level == LVL_3 && ent_large) begin
            walk_status = STS_PAGE_1G;
            walk_frame  = ent_frame;
            walk_pa     = frame_base | PA_W'(r_va[29:0]);
        end else if (r_level == LVL_2 && ent_large) begin
            walk_status = STS_PAGE_2M;
            walk_frame  = ent_frame;
            walk_pa     = frame_base | PA_W'(r_va[20:0]);
        end else if (frame_oob) begin
            walk_status = STS_BAD_TABLE;
        end else begin
            // top-level large bit is ignored, entry points to the next table
            walk_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_va          <= i_virtual_address;
            r_level       <= LVL_4;
            r_table       <= PAGE_W'(i_root_page);
            r_pend_status <= item_write ? STS_WRITE_DONE : STS_BAD_TABLE;
        end else if (i_cmd.walk_step) begin
            r_level <= r_level - 1'b1;
            r_table <= PAGE_W'(ent_frame);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_walk || i_cmd.load_resp) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_walk) begin
            r_out_status <= walk_status;
            r_out_frame  <= walk_frame;
            r_out_pa     <= walk_pa;
            r_out_leaf   <= walk_leaf;
        end else if (i_cmd.load_resp) begin
            r_out_status <= r_pend_status;
            r_out_frame  <= '0;
            r_out_pa     <= '0;
            r_out_leaf   <= '0;
        end
    end

    always_comb begin
        o_stat.clear_last = (32'(r_clr_addr) == STORE_DEPTH - 1);
        o_stat.item_write = item_write;
        o_stat.root_oob   = root_oob;
        o_stat.walk_done  = walk_done;
        o_stat.out_free   = !r_out_valid || !i_stall;
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_out_status;
    assign o_frame_number     = r_out_frame;
    assign o_physical_address = r_out_pa;
    assign o_leaf_table_page  = r_out_leaf;

endmodule

`default_nettype wire

[rtl/fltw_checker.sv]
// ----------------------------------------------------------------------------
// fltw_checker
// Port-level checks of the page-table walker, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fltw_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic                            o_stall,
    input  wire logic                            o_valid,
    input  wire logic                            i_stall,
    input  wire logic [fltw_pkg::STATUS_W-1:0]   o_status,
    input  wire logic [fltw_pkg::FRAME_W-1:0]    o_frame_number,
    input  wire logic [fltw_pkg::PA_W-1:0]       o_physical_address,
    input  wire logic [fltw_pkg::FRAME_W-1:0]    o_leaf_table_page
);
    import fltw_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_physical_address))
        else $error("stalled result changed");

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken while previous one still in flight");

    // a new result only comes from a request in flight
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a request in flight");

    // results without a leaf carry zero fields
    a_no_leaf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STS_WRITE_DONE || o_status == STS_NOT_MAPPED
            || o_status == STS_BAD_TABLE)
        |-> o_frame_number == '0 && o_physical_address == '0
            && o_leaf_table_page == '0)
        else $error("non-leaf result with nonzero fields");

    // 4 KiB leaf address carries the frame number above the page offset
    a_4k_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STS_PAGE_4K
        |-> o_physical_address[PA_W-1:OFFS_W] == o_frame_number)
        else $error("4 KiB physical address does not match frame");

endmodule

bind four_level_page_table_walker fltw_checker u_fltw_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_status           (o_status),
    .o_frame_number     (o_frame_number),
    .o_physical_address (o_physical_address),
    .o_leaf_table_page  (o_leaf_table_page)
);

`default_nettype wire
